@@ hdl/wavetable_morph_sample_unit_defines.svh @@
// Assertion macros for the wavetable morph sample unit checker.
`ifndef WAVETABLE_MORPH_SAMPLE_UNIT_DEFINES_SVH
`define WAVETABLE_MORPH_SAMPLE_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define WMS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define WMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/wms_pkg.sv @@
// Shared constants, types and the quarter-wave sine table for the morph sample unit.
package wms_pkg;

    localparam int TABLE_SIZE  = 2048;
    localparam int SAMPLE_BITS = 16;
    localparam int PHASE_BITS  = 11;
    localparam int Q15_BITS    = 16;

    localparam int IDX_BITS  = $clog2(TABLE_SIZE);
    localparam int QUARTER   = TABLE_SIZE / 4;
    localparam int QTR_BITS  = $clog2(QUARTER);
    localparam int WAVE_WIDE = SAMPLE_BITS + IDX_BITS + 3;

    localparam longint FULL_SCALE = longint'(1) << (SAMPLE_BITS - 1);

    localparam int POS_BITS  = 12;
    localparam int POS_MAX   = 3000;
    localparam int POS_STEP  = 1000;
    localparam int FRAC_BITS = $clog2(POS_STEP + 1);

    localparam longint Q15_BIAS    = longint'(1) << (Q15_BITS - 1);
    localparam longint BLEND_ROUND = POS_STEP / 2;
    localparam longint BLEND_BIAS  = Q15_BIAS * POS_STEP;
    localparam int     SUM_BITS    = $clog2(2 * BLEND_BIAS + BLEND_ROUND + 1);
    localparam int     RECIP_SHIFT = SUM_BITS + FRAC_BITS;
    localparam longint RECIP_MULT  = ((longint'(1) << RECIP_SHIFT) + POS_STEP - 1) / POS_STEP;
    localparam int     RECIP_BITS  = $clog2(RECIP_MULT + 1);
    localparam int     PROD_BITS   = SUM_BITS + RECIP_BITS;
    localparam int     QUO_BITS    = PROD_BITS - RECIP_SHIFT;

    localparam int Q15_SHR = (SAMPLE_BITS > Q15_BITS) ? SAMPLE_BITS - Q15_BITS : 0;
    localparam int Q15_SHL = (Q15_BITS > SAMPLE_BITS) ? Q15_BITS - SAMPLE_BITS : 0;

    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        WAVE_SINE,
        WAVE_TRIANGLE,
        WAVE_SAW,
        WAVE_SQUARE
    } wave_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [Q15_BITS-1:0]    q15_t;
    typedef logic signed [WAVE_WIDE-1:0]   wide_t;
    typedef sample_t                       sine_rom_t [QUARTER];

    localparam sample_t SAMPLE_MAX = sample_t'(FULL_SCALE - 1);
    localparam sample_t SAMPLE_MIN = sample_t'(-FULL_SCALE);
    localparam wide_t   WIDE_MAX   = wide_t'(FULL_SCALE - 1);
    localparam wide_t   WIDE_MIN   = wide_t'(-FULL_SCALE);

    // Fixed-point sine of quarter-wave step j (0 .. QUARTER), Horner series to x^13.
    function automatic sample_t sine_quarter(int j);
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        r = 64'(j) << (30 - QTR_BITS);
        x = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t = ONE_Q30;
        t = ONE_Q30 - ((x2 * t) >> 30) / 64'd156;
        t = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
        t = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
        t = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        s = (x * t) >> 30;
        v = (s * 64'(FULL_SCALE) + (ONE_Q30 >> 1)) >> 30;
        if (v > 64'(FULL_SCALE - 1))
        begin
            v = 64'(FULL_SCALE - 1);
        end
        return sample_t'(v);
    endfunction

    // Entry n holds the sine of quarter step n + 1; step 0 is zero and not stored.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int n = 0; n < QUARTER; n++)
        begin
            rom[n] = sine_quarter(n + 1);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    function automatic sample_t clip_sample(wide_t v);
        sample_t res;
        if (v > WIDE_MAX)
        begin
            res = SAMPLE_MAX;
        end
        else if (v < WIDE_MIN)
        begin
            res = SAMPLE_MIN;
        end
        else
        begin
            res = sample_t'(v);
        end
        return res;
    endfunction

    function automatic q15_t to_q15(sample_t v);
        logic signed [31:0] w;
        w = 32'(v);
        return q15_t'((w >>> Q15_SHR) <<< Q15_SHL);
    endfunction

endpackage

@@ hdl/wms_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module wms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/wavetable_morph_sample_unit.sv @@
// Top level: wavetable crossfade sample unit (sine, triangle, sawtooth, square).
//
// Input channel: phase_index with in_valid / in_stall. Output channel: blended_sample,
// lower_sample and upper_sample with out_valid / out_stall. A transaction completes on
// a rising edge with valid high and stall low.
// wave_position is written on any edge with wave_position_wr_en high; change it only
// while no transaction is in flight. Values above 3000 act as 3000.
// Pipeline: a result passes the sine RAM read, waveform select, weighted sum and reciprocal
// divide by 1000, and is registered on the output.
// Throughput: one transaction per cycle while in_stall is low; four pipeline stages each hold one item and
// fill bubbles independently, so input is taken while a result waits on the output.
// Reset: the quarter-wave sine RAM is loaded from the constant table, one entry per
// cycle, until all 512 entries are written after reset; in_stall stays high meanwhile.
// Output stall holds the output register; earlier stages keep taking items until all
// stages are full, then in_stall rises.
module wavetable_morph_sample_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    wave_position_wr_en,
    input  logic [wms_pkg::POS_BITS-1:0]            wave_position,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [wms_pkg::PHASE_BITS-1:0]          phase_index,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [wms_pkg::Q15_BITS-1:0]     blended_sample,
    output logic signed [wms_pkg::Q15_BITS-1:0]     lower_sample,
    output logic signed [wms_pkg::Q15_BITS-1:0]     upper_sample
);

    localparam int IDX_BITS  = wms_pkg::IDX_BITS;
    localparam int QTR_BITS  = wms_pkg::QTR_BITS;
    localparam int FRAC_BITS = wms_pkg::FRAC_BITS;
    localparam int POS_BITS  = wms_pkg::POS_BITS;
    localparam int SUM_BITS  = wms_pkg::SUM_BITS;
    localparam int PROD_BITS = wms_pkg::PROD_BITS;
    localparam int QUO_BITS  = wms_pkg::QUO_BITS;

    typedef logic signed [SUM_BITS+1:0] sum_t;
    typedef logic signed [QUO_BITS:0]   quo_t;

    // configuration
    logic [POS_BITS-1:0]  wave_position_reg;
    logic [POS_BITS-1:0]  pos_clamped;
    logic [POS_BITS-1:0]  pos_base;
    wms_pkg::wave_t       lower_wave;
    wms_pkg::wave_t       upper_wave;
    logic [FRAC_BITS-1:0] frac;
    logic [FRAC_BITS-1:0] frac_inv;

    // sine RAM load after reset
    logic                fill_busy_reg;
    logic [QTR_BITS-1:0] fill_cnt_reg;

    // handshake
    logic ready1;
    logic ready2;
    logic ready3;
    logic ready4;
    logic in_accept;

    // stage 1
    logic                v1_reg;
    logic [IDX_BITS-1:0] idx1_reg;
    logic                neg1_reg;
    logic                zero1_reg;
    logic [IDX_BITS-1:0] idx_in;
    logic [1:0]          quad_in;
    logic [QTR_BITS-1:0] low_in;
    logic [QTR_BITS-1:0] rom_addr;
    wms_pkg::sample_t    sine_mag;

    // stage 2
    logic                v2_reg;
    wms_pkg::q15_t       a2_reg;
    wms_pkg::q15_t       b2_reg;
    wms_pkg::sample_t    sine_val;
    wms_pkg::sample_t    tri_val;
    wms_pkg::sample_t    saw_val;
    wms_pkg::sample_t    sq_val;
    logic [IDX_BITS:0]   idx_ext;
    logic [IDX_BITS:0]   idx_mirror;
    logic [IDX_BITS:0]   tri_dist;
    wms_pkg::wide_t      tri_wide;
    wms_pkg::wide_t      saw_wide;

    // stage 3
    logic                v3_reg;
    logic [SUM_BITS-1:0] x3_reg;
    wms_pkg::q15_t       a3_reg;
    wms_pkg::q15_t       b3_reg;
    sum_t                sum_next;

    // stage 4 (output)
    logic                 out_valid_reg;
    wms_pkg::q15_t        blended_reg;
    wms_pkg::q15_t        lower_reg;
    wms_pkg::q15_t        upper_reg;
    logic [PROD_BITS-1:0] prod;
    quo_t                 blend_wide;
    wms_pkg::q15_t        blend_next;

    function automatic wms_pkg::sample_t pick_wave(wms_pkg::wave_t w,
                                                   wms_pkg::sample_t s_sine,
                                                   wms_pkg::sample_t s_tri,
                                                   wms_pkg::sample_t s_saw,
                                                   wms_pkg::sample_t s_sq);
        wms_pkg::sample_t res;
        unique case (w)
            wms_pkg::WAVE_SINE:     res = s_sine;
            wms_pkg::WAVE_TRIANGLE: res = s_tri;
            wms_pkg::WAVE_SAW:      res = s_saw;
            wms_pkg::WAVE_SQUARE:   res = s_sq;
            default:                res = s_sq;
        endcase
        return res;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_position_reg <= '0;
        end
        else if (wave_position_wr_en)
        begin
            wave_position_reg <= wave_position;
        end
    end

    always_comb
    begin
        pos_clamped = (wave_position_reg > POS_BITS'(wms_pkg::POS_MAX)) ?
                      POS_BITS'(wms_pkg::POS_MAX) : wave_position_reg;
        priority if (pos_clamped >= POS_BITS'(2 * wms_pkg::POS_STEP))
        begin
            lower_wave = wms_pkg::WAVE_SAW;
            upper_wave = wms_pkg::WAVE_SQUARE;
            pos_base   = POS_BITS'(2 * wms_pkg::POS_STEP);
        end
        else if (pos_clamped >= POS_BITS'(wms_pkg::POS_STEP))
        begin
            lower_wave = wms_pkg::WAVE_TRIANGLE;
            upper_wave = wms_pkg::WAVE_SAW;
            pos_base   = POS_BITS'(wms_pkg::POS_STEP);
        end
        else
        begin
            lower_wave = wms_pkg::WAVE_SINE;
            upper_wave = wms_pkg::WAVE_TRIANGLE;
            pos_base   = '0;
        end
        frac     = FRAC_BITS'(pos_clamped - pos_base);
        frac_inv = FRAC_BITS'(wms_pkg::POS_STEP) - frac;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_busy_reg <= 1'b1;
            fill_cnt_reg  <= '0;
        end
        else if (fill_busy_reg)
        begin
            fill_cnt_reg <= fill_cnt_reg + 1'b1;
            if (fill_cnt_reg == QTR_BITS'(wms_pkg::QUARTER - 1))
            begin
                fill_busy_reg <= 1'b0;
            end
        end
    end

    assign ready4    = !out_valid_reg || !out_stall;
    assign ready3    = !v3_reg || ready4;
    assign ready2    = !v2_reg || ready3;
    assign ready1    = !v1_reg || ready2;
    assign in_stall  = fill_busy_reg || !ready1;
    assign in_accept = in_valid && !in_stall;

    // quarter-wave fold: odd quadrants mirror, the upper half negates
    always_comb
    begin
        idx_in   = phase_index[IDX_BITS-1:0];
        quad_in  = idx_in[IDX_BITS-1 -: 2];
        low_in   = idx_in[QTR_BITS-1:0];
        rom_addr = quad_in[0] ? ~low_in : low_in - 1'b1;
    end

    wms_ram #(
        .WIDTH (wms_pkg::SAMPLE_BITS),
        .DEPTH (wms_pkg::QUARTER)
    ) u_sine_ram (
        .clk   (clk),
        .we    (fill_busy_reg),
        .waddr (fill_cnt_reg),
        .wdata (wms_pkg::SINE_ROM[fill_cnt_reg]),
        .re    (in_accept),
        .raddr (rom_addr),
        .rdata (sine_mag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_accept;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready4)
            begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            idx1_reg  <= idx_in;
            neg1_reg  <= quad_in[1];
            zero1_reg <= !quad_in[0] && (low_in == '0);
        end
    end

    always_comb
    begin
        sine_val   = zero1_reg ? '0 : (neg1_reg ? -sine_mag : sine_mag);
        idx_ext    = {1'b0, idx1_reg};
        idx_mirror = (IDX_BITS + 1)'(wms_pkg::TABLE_SIZE) - idx_ext;
        tri_dist   = (idx_ext < idx_mirror) ? idx_ext : idx_mirror;
        tri_wide   = ((wms_pkg::wide_t'(wms_pkg::TABLE_SIZE)
                     - (wms_pkg::wide_t'(tri_dist) <<< 2)) <<< wms_pkg::SAMPLE_BITS)
                     + wms_pkg::wide_t'(wms_pkg::TABLE_SIZE);
        saw_wide   = (((wms_pkg::wide_t'(idx_ext) <<< 1)
                     - wms_pkg::wide_t'(wms_pkg::TABLE_SIZE)) <<< wms_pkg::SAMPLE_BITS)
                     + wms_pkg::wide_t'(wms_pkg::TABLE_SIZE);
        tri_val    = wms_pkg::clip_sample(tri_wide >>> (IDX_BITS + 1));
        saw_val    = wms_pkg::clip_sample(saw_wide >>> (IDX_BITS + 1));
        sq_val     = idx1_reg[IDX_BITS-1] ? wms_pkg::SAMPLE_MIN : wms_pkg::SAMPLE_MAX;
    end

    always_ff @(posedge clk)
    begin
        if (ready2)
        begin
            a2_reg <= wms_pkg::to_q15(pick_wave(lower_wave, sine_val, tri_val,
                                                saw_val, sq_val));
            b2_reg <= wms_pkg::to_q15(pick_wave(upper_wave, sine_val, tri_val,
                                                saw_val, sq_val));
        end
    end

    // biased so the sum is never negative; the bias is removed after the divide
    assign sum_next = sum_t'(a2_reg) * sum_t'($signed({1'b0, frac_inv}))
                    + sum_t'(b2_reg) * sum_t'($signed({1'b0, frac}))
                    + sum_t'(wms_pkg::BLEND_ROUND + wms_pkg::BLEND_BIAS);

    always_ff @(posedge clk)
    begin
        if (ready3)
        begin
            x3_reg <= sum_next[SUM_BITS-1:0];
            a3_reg <= a2_reg;
            b3_reg <= b2_reg;
        end
    end

    // floor divide by 1000 via reciprocal multiply
    always_comb
    begin
        prod       = PROD_BITS'(x3_reg) * PROD_BITS'(wms_pkg::RECIP_MULT);
        blend_wide = $signed({1'b0, prod[PROD_BITS-1:wms_pkg::RECIP_SHIFT]})
                   - quo_t'(wms_pkg::Q15_BIAS);
        if (blend_wide > quo_t'(wms_pkg::Q15_BIAS - 1))
        begin
            blend_next = wms_pkg::q15_t'(wms_pkg::Q15_BIAS - 1);
        end
        else if (blend_wide < quo_t'(-wms_pkg::Q15_BIAS))
        begin
            blend_next = wms_pkg::q15_t'(-wms_pkg::Q15_BIAS);
        end
        else
        begin
            blend_next = wms_pkg::q15_t'(blend_wide);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready4)
        begin
            blended_reg <= blend_next;
            lower_reg   <= a3_reg;
            upper_reg   <= b3_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign blended_sample = blended_reg;
    assign lower_sample   = lower_reg;
    assign upper_sample   = upper_reg;

endmodule

@@ hdl/wms_checker.sv @@
// Port-level assertions for the wavetable morph sample unit, bound to the top level.
`include "wavetable_morph_sample_unit_defines.svh"

module wms_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [wms_pkg::Q15_BITS-1:0] blended_sample,
    input logic signed [wms_pkg::Q15_BITS-1:0] lower_sample,
    input logic signed [wms_pkg::Q15_BITS-1:0] upper_sample
);

    `WMS_ASSERT_NEXT(a_out_valid_held, out_valid && out_stall, out_valid, "out_valid dropped while stalled")

    `WMS_ASSERT_NEXT(a_out_payload_held, out_valid && out_stall, $stable(blended_sample) && $stable(lower_sample) && $stable(upper_sample), "output changed while stalled")

    // a crossfade never leaves the span of its two neighbors
    `WMS_ASSERT_SAME(a_blend_in_span, out_valid, (blended_sample >= lower_sample && blended_sample <= upper_sample) || (blended_sample <= lower_sample && blended_sample >= upper_sample), "blend outside neighbor span")

    `WMS_ASSERT_SAME(a_blend_equal_neighbors, out_valid && lower_sample == upper_sample, blended_sample == lower_sample, "blend of equal neighbors differs")

endmodule

bind wavetable_morph_sample_unit wms_checker u_wms_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .blended_sample (blended_sample),
    .lower_sample   (lower_sample),
    .upper_sample   (upper_sample)
);

@@ sim/wavetable_morph_sample_unit_checker.sv @@
// Transaction checker: predicts morph samples from observed inputs and compares outputs.
module wavetable_morph_sample_unit_checker
    import wms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wave_position_wr_en,
    input  logic [POS_BITS-1:0]   wave_position,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [PHASE_BITS-1:0] phase_index,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  q15_t                  blended_sample,
    input  q15_t                  lower_sample,
    input  q15_t                  upper_sample,
    output int                    mismatch_count,
    output int                    samples_outstanding
);

    typedef struct packed {
        q15_t blended;
        q15_t lower;
        q15_t upper;
    } morph_sample_t;

    logic [POS_BITS-1:0] position;
    morph_sample_t       samples_due [$];

    function automatic longint floor_quot(longint num, longint den);
        longint q;
        q = num / den;
        if (num % den != 0 && num < 0)
        begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic longint sine_point(int idx);
        logic [63:0] turn;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] div;
        logic [1:0]  quad;
        turn = (64'(idx) << 32) / 64'(TABLE_SIZE);
        quad = turn[31:30];
        r = turn & (ONE_Q30 - 64'd1);
        if (quad[0])
        begin
            r = ONE_Q30 - r;
        end
        x = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t = ONE_Q30;
        for (int n = 0; n < 6; n++)
        begin
            case (n)
                0:       div = 64'd156;
                1:       div = 64'd110;
                2:       div = 64'd72;
                3:       div = 64'd42;
                4:       div = 64'd20;
                default: div = 64'd6;
            endcase
            t = ONE_Q30 - ((x2 * t) >> 30) / div;
        end
        s = (x * t) >> 30;
        v = (s * 64'(FULL_SCALE) + (ONE_Q30 >> 1)) >> 30;
        if (v > 64'(FULL_SCALE - 1))
        begin
            v = 64'(FULL_SCALE - 1);
        end
        return quad[1] ? -longint'(v) : longint'(v);
    endfunction

    // One waveform sample, already scaled to Q1.15.
    function automatic longint wave_point(wave_t shape, int idx);
        longint sc;
        longint v;
        longint d;
        sc = FULL_SCALE;
        d = (idx < TABLE_SIZE - idx) ? idx : TABLE_SIZE - idx;
        case (shape)
            WAVE_SINE:     v = sine_point(idx);
            WAVE_TRIANGLE: v = floor_quot(2 * sc * (TABLE_SIZE - 4 * d) + TABLE_SIZE,
                                          2 * TABLE_SIZE);
            WAVE_SAW:      v = floor_quot(2 * sc * (2 * idx - TABLE_SIZE) + TABLE_SIZE,
                                          2 * TABLE_SIZE);
            default:       v = (2 * idx < TABLE_SIZE) ? sc : -sc;
        endcase
        if (v > sc - 1)
        begin
            v = sc - 1;
        end
        if (v < -sc)
        begin
            v = -sc;
        end
        return floor_quot(v, longint'(1) << Q15_SHR) * (longint'(1) << Q15_SHL);
    endfunction

    function automatic morph_sample_t morph_sample(logic [POS_BITS-1:0] pos_reg,
                                                   logic [PHASE_BITS-1:0] idx);
        morph_sample_t res;
        longint        pos;
        longint        f;
        longint        a;
        longint        b;
        longint        m;
        int            k;
        int            i;
        pos = (pos_reg > POS_MAX) ? POS_MAX : longint'(pos_reg);
        k = int'(pos / POS_STEP);
        if (k > int'(WAVE_SAW))
        begin
            k = int'(WAVE_SAW);
        end
        f = pos - POS_STEP * k;
        i = int'(idx) % TABLE_SIZE;
        a = wave_point(wave_t'(k), i);
        b = wave_point(wave_t'(k + 1), i);
        m = floor_quot(a * (POS_STEP - f) + b * f + POS_STEP / 2, POS_STEP);
        if (m > 32767)
        begin
            m = 32767;
        end
        if (m < -32768)
        begin
            m = -32768;
        end
        res.blended = q15_t'(m);
        res.lower = q15_t'(a);
        res.upper = q15_t'(b);
        return res;
    endfunction

    task automatic check_field(string field, q15_t want, q15_t got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t %s expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        morph_sample_t want;
        if (!rst_n)
        begin
            position = '0;
            samples_due.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                samples_due.push_back(morph_sample(position, phase_index));
            end
            if (out_valid && !out_stall)
            begin
                if (samples_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t unexpected transaction: expected none actual %0d %0d %0d",
                             $time, blended_sample, lower_sample, upper_sample);
                end
                else
                begin
                    want = samples_due.pop_front();
                    check_field("blended_sample", want.blended, blended_sample);
                    check_field("lower_sample", want.lower, lower_sample);
                    check_field("upper_sample", want.upper, upper_sample);
                end
            end
            if (wave_position_wr_en)
            begin
                position = wave_position;
            end
        end
        samples_outstanding = samples_due.size();
    end

endmodule

@@ sim/wavetable_morph_sample_unit_test.sv @@
// Testbench top: stimulus, output stall pattern and verdict for the morph sample unit.
module wavetable_morph_sample_unit_test;
    import wms_pkg::*;

    localparam int TIMEOUT     = 1000000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 150;
    localparam int IDLE_PCT    = 37;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  wave_position_wr_en = 1'b0;
    logic [POS_BITS-1:0]   wave_position = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [PHASE_BITS-1:0] phase_index = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    q15_t                  blended_sample;
    q15_t                  lower_sample;
    q15_t                  upper_sample;

    int mismatch_count;
    int samples_outstanding;
    int in_idle_pct = IDLE_PCT;
    int out_idle_pct = IDLE_PCT;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    wavetable_morph_sample_unit uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .wave_position_wr_en (wave_position_wr_en),
        .wave_position       (wave_position),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .phase_index         (phase_index),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .blended_sample      (blended_sample),
        .lower_sample        (lower_sample),
        .upper_sample        (upper_sample)
    );

    wavetable_morph_sample_unit_checker sample_check (
        .clk                 (clk),
        .rst_n               (rst_n),
        .wave_position_wr_en (wave_position_wr_en),
        .wave_position       (wave_position),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .phase_index         (phase_index),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .blended_sample      (blended_sample),
        .lower_sample        (lower_sample),
        .upper_sample        (upper_sample),
        .mismatch_count      (mismatch_count),
        .samples_outstanding (samples_outstanding)
    );

    always #4 clk = ~clk;

    // Output stall: random, or a long hold when requested.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_requests != holds_served)
        begin
            holds_served = holds_served + 1;
            hold_left = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= (int'($urandom_range(0, 99)) < out_idle_pct);
        end
    end

    task automatic offer_phase(input logic [PHASE_BITS-1:0] idx);
        @(negedge clk);
        while (int'($urandom_range(0, 99)) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        phase_index <= idx;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (samples_outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic set_position(input int pos);
        drain();
        @(negedge clk);
        wave_position_wr_en <= 1'b1;
        wave_position <= POS_BITS'(pos);
        @(negedge clk);
        wave_position_wr_en <= 1'b0;
    endtask

    function automatic logic [PHASE_BITS-1:0] pick_phase();
        int idx;
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 7))
                0:       idx = 0;
                1:       idx = QUARTER - 1;
                2:       idx = QUARTER;
                3:       idx = 2 * QUARTER - 1;
                4:       idx = 2 * QUARTER;
                5:       idx = 3 * QUARTER - 1;
                6:       idx = 3 * QUARTER;
                default: idx = TABLE_SIZE - 1;
            endcase
        end
        else
        begin
            idx = int'($urandom_range(0, TABLE_SIZE - 1));
        end
        return PHASE_BITS'(idx);
    endfunction

    function automatic int pick_position();
        if ($urandom_range(0, 4) == 0)
        begin
            return int'($urandom_range(POS_MAX + 1, (1 << POS_BITS) - 1));
        end
        return int'($urandom_range(0, POS_MAX));
    endfunction

    initial
    begin
        static int corner_positions [5] = '{0, POS_STEP, 2 * POS_STEP, POS_MAX,
                                            (1 << POS_BITS) - 1};
        static int corner_phases [5] = '{0, QUARTER, 2 * QUARTER - 1, 2 * QUARTER,
                                         TABLE_SIZE - 1};
        static int edge_positions [4] = '{POS_MAX - 1, POS_STEP + 1, 1, 2 * POS_STEP + 1};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (corner_positions[p])
        begin
            set_position(corner_positions[p]);
            foreach (corner_phases[n])
            begin
                offer_phase(PHASE_BITS'(corner_phases[n]));
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_position(ph < 4 ? edge_positions[ph] : pick_position());
            in_idle_pct = (ph == 5) ? 0 : IDLE_PCT;
            out_idle_pct = (ph == 5) ? 0 : IDLE_PCT;
            if (ph == 7)
            begin
                hold_requests++;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 9 && n == PHASE_ITEMS / 2)
                begin
                    drain();
                end
                offer_phase(pick_phase());
            end
        end

        drain();
        repeat (20) @(negedge clk);
        if (mismatch_count == 0 && samples_outstanding == 0)
        begin
            $display("wavetable_morph_sample_unit: match");
        end
        else
        begin
            $display("wavetable_morph_sample_unit: mismatch");
        end
        $finish;
    end

    initial
    begin
        #TIMEOUT;
        $display("wavetable_morph_sample_unit: mismatch");
        $finish;
    end

endmodule
